### sv/assert_macros.svh
// Assertion helpers for the path interpolator; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/wpi_pkg.sv
package wpi_pkg;

    localparam int SPEED_W   = 16;
    localparam int ELAPSED_W = 19;
    localparam int COORD_W   = 32;
    localparam int SEG_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int T_W       = 17;
    localparam int Q_W       = 16;
    localparam int TICKS_W   = 11;
    localparam int RECIP_W   = 22;
    localparam int RECIP_SH  = 32;
    localparam int NUM_W     = ELAPSED_W + 8;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam int POS_W     = 35;
    localparam int DELTA_W   = 21;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SEG_W-1:0]          seg_t;

    localparam seg_t SEG_FIRST = 2'd0;
    localparam seg_t SEG_MID   = 2'd1;
    localparam seg_t SEG_LAST  = 2'd2;
    localparam seg_t SEG_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [TICKS_W-1:0] TICKS_SHORT = 11'd1200;
    localparam logic [TICKS_W-1:0] TICKS_LONG  = 11'd1500;

    localparam logic [ELAPSED_W-1:0] DQ_SHORT = ELAPSED_W'(1200 * 256);
    localparam logic [ELAPSED_W-1:0] DQ_LONG  = ELAPSED_W'(1500 * 256);

    // floor(2^32 / ticks); the quotient estimate is at most one low
    localparam logic [RECIP_W-1:0] RECIP_SHORT = RECIP_W'(64'd4294967296 / 64'd1200);
    localparam logic [RECIP_W-1:0] RECIP_LONG  = RECIP_W'(64'd4294967296 / 64'd1500);

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic signed [POS_W-1:0] OFF_ZERO    = '0;
    localparam logic signed [POS_W-1:0] OFF_NEG_TEN = -35'sd655360;

    typedef struct packed {
        seg_t                  seg;
        seg_t                  seg_after;
        logic                  wrap;
        logic [ELAPSED_W-1:0]  elapsed;
    } item_t;

    function automatic logic [ELAPSED_W-1:0] seg_dq(input seg_t seg);
        logic [ELAPSED_W-1:0] dq;
        case (seg)
            SEG_LAST: dq = DQ_LONG;
            default:  dq = DQ_SHORT;
        endcase
        return dq;
    endfunction

    function automatic logic [TICKS_W-1:0] seg_ticks(input seg_t seg);
        logic [TICKS_W-1:0] ticks;
        case (seg)
            SEG_LAST: ticks = TICKS_LONG;
            default:  ticks = TICKS_SHORT;
        endcase
        return ticks;
    endfunction

    function automatic logic [RECIP_W-1:0] seg_recip(input seg_t seg);
        logic [RECIP_W-1:0] recip;
        case (seg)
            SEG_LAST: recip = RECIP_LONG;
            default:  recip = RECIP_SHORT;
        endcase
        return recip;
    endfunction

    // Start point of a segment relative to the origin, Q16.16
    function automatic logic signed [POS_W-1:0] seg_start_off(input seg_t seg,
                                                              input logic [1:0] axis);
        logic signed [POS_W-1:0] off;
        off = OFF_ZERO;
        case (seg)
            SEG_MID:  if (axis == AXIS_Z) off = OFF_NEG_TEN;
            SEG_LAST: if (axis == AXIS_X || axis == AXIS_Z) off = OFF_NEG_TEN;
            default:  off = OFF_ZERO;
        endcase
        return off;
    endfunction

    // Travel direction of a segment along an axis; every move spans ten units
    function automatic logic [1:0] seg_dir(input seg_t seg, input logic [1:0] axis);
        logic [1:0] dir;
        dir = DIR_HOLD;
        case (seg)
            SEG_FIRST: if (axis == AXIS_Z) dir = DIR_DOWN;
            SEG_MID:   if (axis == AXIS_X) dir = DIR_DOWN;
            SEG_LAST:  if (axis == AXIS_X || axis == AXIS_Z) dir = DIR_UP;
            default:   dir = DIR_HOLD;
        endcase
        return dir;
    endfunction

endpackage

### sv/waypoint_path_interpolator.sv
// An accepted speed word goes into the queue; the back end then takes it through its pop,
// multiply, fix and load steps and pops the next word only after loading this one's output.
// The front end takes words every cycle until the queue (QUEUE_DEPTH words) fills.
// The output register holds a finished word while the back end starts the next one.
// Reset clears elapsed count, segment index, origins, queue and output valid at once;
// there is no clearing pass, and configuration writes are taken in every cycle.
`include "assert_macros.svh"

module waypoint_path_interpolator
    import wpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SPEED_W-1:0]   speed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output coord_t               pos_x,
    output coord_t               pos_y,
    output coord_t               pos_z,
    output seg_t                 segment,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    coord_t           origin_x_reg;
    coord_t           origin_x_next;
    coord_t           origin_y_reg;
    coord_t           origin_y_next;
    coord_t           origin_z_reg;
    coord_t           origin_z_next;

    logic             q_space;
    logic             q_push;
    item_t            push_item;
    logic             q_valid;
    logic             q_pop;
    item_t            pop_item;
    logic [CNT_W-1:0] q_level;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        origin_z_next = origin_z_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_next = cfg_data;
                CFG_ORIGIN_Y: origin_y_next = cfg_data;
                CFG_ORIGIN_Z: origin_z_next = cfg_data;
                default:      ; // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            origin_z_reg <= origin_z_next;
        end
    end

    wpi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .speed    (speed),
        .q_space  (q_space),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    wpi_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .space     (q_space),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item),
        .level     (q_level)
    );

    wpi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (pop_item),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .segment   (segment)
    );

    `ASSERT_IMPLIES(a_seg_range, out_valid, segment != SEG_NONE, "segment index out of range")
    `ASSERT_ALWAYS(a_level_bound, q_level <= CNT_W'(QUEUE_DEPTH), "queue level past depth")
    `ASSERT_ALWAYS(a_level_step, (q_level == $past(q_level)) || (q_level == $past(q_level) + CNT_W'(1)) || (q_level + CNT_W'(1) == $past(q_level)), "queue level jumped")
    `ASSERT_IMPLIES(a_push_space, in_valid && in_ready, q_level != CNT_W'(QUEUE_DEPTH), "word accepted into a full queue")

endmodule

### sv/wpi_front.sv
module wpi_front
    import wpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SPEED_W-1:0]  speed,
    input  logic                q_space,
    output logic                q_push,
    output item_t               q_item
);

    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    seg_t                 seg_reg;
    seg_t                 seg_next;

    logic [ELAPSED_W:0]   sum_full;
    logic [ELAPSED_W-1:0] sum;
    seg_t                 seg_cur;
    seg_t                 seg_after;
    logic                 wrap;
    logic                 accept;

    assign in_ready = q_space;
    assign accept   = in_valid && q_space;
    assign q_push   = accept;

    always_comb
    begin
        sum_full = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(speed);
        sum      = sum_full[ELAPSED_W-1:0];
        seg_cur  = (seg_reg == SEG_NONE) ? SEG_FIRST : seg_reg;
        wrap     = (sum >= seg_dq(seg_cur));
        if (!wrap)
            seg_after = seg_cur;
        else if (seg_cur == SEG_LAST)
            seg_after = SEG_FIRST;
        else
            seg_after = seg_cur + SEG_W'(1);

        q_item.seg       = seg_cur;
        q_item.seg_after = seg_after;
        q_item.wrap      = wrap;
        q_item.elapsed   = sum;

        elapsed_next = elapsed_reg;
        seg_next     = seg_reg;
        if (accept)
        begin
            // clear the count when the segment end is reached
            elapsed_next = wrap ? '0 : sum;
            seg_next     = seg_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            seg_reg     <= SEG_FIRST;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            seg_reg     <= seg_next;
        end
    end

endmodule

### sv/wpi_fifo.sv
module wpi_fifo
    import wpi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    output logic                       space,
    input  logic                       pop,
    output logic                       not_empty,
    output item_t                      pop_item,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign space     = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && space;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entries[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/wpi_back.sv
module wpi_back
    import wpi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    output logic   q_pop,
    input  item_t  q_item,
    input  coord_t origin_x,
    input  coord_t origin_y,
    input  coord_t origin_z,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t pos_x,
    output coord_t pos_y,
    output coord_t pos_z,
    output seg_t   segment
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_FIX  = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    item_t              item_reg;
    item_t              item_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [T_W-1:0]     t_reg;
    logic [T_W-1:0]     t_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    coord_t             pos_x_reg;
    coord_t             pos_x_next;
    coord_t             pos_y_reg;
    coord_t             pos_y_next;
    coord_t             pos_z_reg;
    coord_t             pos_z_next;
    seg_t               segment_reg;
    seg_t               segment_next;

    logic [NUM_W-1:0]   num;
    logic [Q_W-1:0]     q_est;
    logic [TICKS_W-1:0] divisor;
    logic [NUM_W-1:0]   rem;
    logic [T_W-1:0]     q_fix;
    logic [DELTA_W-1:0] delta;
    logic               out_load;

    function automatic coord_t axis_pos(input coord_t origin, input seg_t seg,
                                        input logic [1:0] axis,
                                        input logic [DELTA_W-1:0] dmag);
        logic signed [POS_W-1:0] sum;
        logic signed [POS_W-1:0] dsig;
        logic [1:0]              dir;
        coord_t                  res;
        dir = seg_dir(seg, axis);
        case (dir)
            DIR_UP:   dsig = POS_W'($signed({1'b0, dmag}));
            DIR_DOWN: dsig = -POS_W'($signed({1'b0, dmag}));
            default:  dsig = '0;
        endcase
        sum = POS_W'(origin) + seg_start_off(seg, axis) + dsig;
        // saturate to the 32-bit range
        if (sum[POS_W-1] && !(&sum[POS_W-2:COORD_W-1]))
            res = {1'b1, {(COORD_W - 1){1'b0}}};
        else if (!sum[POS_W-1] && (|sum[POS_W-2:COORD_W-1]))
            res = {1'b0, {(COORD_W - 1){1'b1}}};
        else
            res = sum[COORD_W-1:0];
        return res;
    endfunction

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign segment   = segment_reg;

    always_comb
    begin
        num       = {item_reg.elapsed, 8'b0};
        divisor   = seg_ticks(item_reg.seg);
        prod_next = PROD_W'(num) * PROD_W'(seg_recip(item_reg.seg));
        q_est     = prod_reg[RECIP_SH +: Q_W];
        // estimate is exact or one low: fix with a single compare
        rem       = num - NUM_W'(NUM_W'(q_est) * NUM_W'(divisor));
        q_fix     = (rem >= NUM_W'(divisor)) ? T_W'(q_est) + T_W'(1) : T_W'(q_est);
        t_next    = item_reg.wrap ? T_ONE : q_fix;
        // ten units per full segment: t*10
        delta     = DELTA_W'({t_reg, 3'b0}) + DELTA_W'({t_reg, 1'b0});

        pos_x_next   = axis_pos(origin_x, item_reg.seg, AXIS_X, delta);
        pos_y_next   = axis_pos(origin_y, item_reg.seg, AXIS_Y, delta);
        pos_z_next   = axis_pos(origin_z, item_reg.seg, AXIS_Z, delta);
        segment_next = item_reg.seg_after;

        item_next  = q_pop ? q_item : item_reg;
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (q_valid) state_next = B_MUL;
            B_MUL:   state_next = B_FIX;
            B_FIX:   state_next = B_OUT;
            B_OUT:   if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (state_reg == B_MUL)
            prod_reg <= prod_next;
        if (state_reg == B_FIX)
            t_reg <= t_next;
        if (out_load)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            segment_reg <= segment_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### bench/waypoint_path_interpolator_tb.sv
module waypoint_path_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wpi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int TAIL_CYCLES = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_WORDS = 330;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        seg_t   seg;
    } pos_word_t;

    // Tracks elapsed time and segment along the path and predicts each position word.
    class path_tracker;
        localparam longint TEN = 655360;

        coord_t               origin [3];
        logic [ELAPSED_W-1:0] elapsed;
        seg_t                 seg_now;
        pos_word_t            pending_pos [$];
        int                   errors;
        int                   checked;
        int                   wraps;
        int                   words;

        function new();
            origin[0] = '0;
            origin[1] = '0;
            origin[2] = '0;
            elapsed   = '0;
            seg_now   = SEG_FIRST;
            errors    = 0;
            checked   = 0;
            wraps     = 0;
            words     = 0;
        endfunction

        function void set_origin(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X: origin[0] = data;
                CFG_ORIGIN_Y: origin[1] = data;
                CFG_ORIGIN_Z: origin[2] = data;
                default: ;  // no register here, drop the write
            endcase
        endfunction

        // Corner k of the closed path relative to the origin, Q16.16
        function longint waypoint(seg_t k, int axis);
            longint off;
            off = 0;
            case (k)
                SEG_MID:  if (axis == AXIS_Z) off = -TEN;
                SEG_LAST: if (axis == AXIS_X || axis == AXIS_Z) off = -TEN;
                default:  off = 0;
            endcase
            return off;
        endfunction

        function coord_t clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return coord_t'(v);
        endfunction

        function void note_speed(logic [SPEED_W-1:0] spd);
            seg_t      s;
            seg_t      nxt;
            longint    dq;
            longint    t;
            longint    o;
            longint    st;
            longint    en;
            coord_t    p [3];
            pos_word_t w;
            s   = (seg_now == SEG_NONE) ? SEG_FIRST : seg_now;
            nxt = (s == SEG_LAST) ? SEG_FIRST : seg_t'(s + 1);
            dq  = (s == SEG_LAST) ? 1500 * 256 : 1200 * 256;
            elapsed = elapsed + spd;
            if (longint'(elapsed) >= dq) begin
                t       = 65536;
                seg_now = nxt;
                elapsed = '0;
                wraps++;
            end
            else begin
                t       = (longint'(elapsed) * 65536) / dq;
                seg_now = s;
            end
            for (int a = 0; a < 3; a++) begin
                o    = longint'(origin[a]);
                st   = o + waypoint(s, a);
                en   = o + waypoint(nxt, a);
                p[a] = clamp(st + (((en - st) * t) >>> 16));
            end
            w.x   = p[0];
            w.y   = p[1];
            w.z   = p[2];
            w.seg = seg_now;
            pending_pos.insert(pending_pos.size(), w);
            words++;
        endfunction

        function void compare_field(string name, longint expv, longint actv);
            if (expv != actv) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void check_position(coord_t x, coord_t y, coord_t z, seg_t sg);
            pos_word_t w;
            if (pending_pos.size() == 0) begin
                $display("%0t: unexpected position word, expected none actual %0d %0d %0d seg %0d",
                         $time, x, y, z, sg);
                errors++;
                return;
            end
            w = pending_pos.pop_front();
            checked++;
            compare_field("pos_x", w.x, x);
            compare_field("pos_y", w.y, y);
            compare_field("pos_z", w.z, z);
            compare_field("segment", w.seg, sg);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [SPEED_W-1:0]   speed = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               pos_z;
    seg_t                 segment;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_count = 0;
    int settings = 0;

    path_tracker tracker = new();

    waypoint_path_interpolator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .speed     (speed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .segment   (segment),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_position(pos_x, pos_y, pos_z, segment);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_speed(input logic [SPEED_W-1:0] spd);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            speed    <= SPEED_W'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        speed    <= spd;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_speed(spd);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold the sender until every expected word is back, then let the pipe settle.
    task automatic wait_for_results();
        end_burst();
        while (tracker.pending_pos.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_origin(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_origin(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z);
        write_reg(CFG_ORIGIN_X, x);
        write_reg(CFG_ORIGIN_Y, y);
        write_reg(CFG_ORIGIN_Z, z);
        write_reg(CFG_UNUSED, $urandom);
        settings++;
    endtask

    task automatic random_speeds(input int n);
        logic [SPEED_W-1:0] spd;
        int                 kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(9);
            case (kind)
                0:       spd = '0;
                1, 2:    spd = SPEED_W'($urandom_range(255));
                3:       spd = '1;
                default: spd = SPEED_W'($urandom);
            endcase
            send_speed(spd);
            if (i % 150 == 149)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset origin, field extremes and every kind of segment end.
        send_idle_pct = 17;
        recv_idle_pct = 50;
        send_speed(16'h0000);
        send_speed(16'h0001);
        send_speed(16'h00FF);
        send_speed(16'h0100);
        repeat (4) send_speed(16'hFFFF);
        send_speed(16'd44548);          // land exactly on the first corner
        repeat (4) send_speed(16'hFFFF);
        send_speed(16'd45061);          // overshoot the second corner by one
        repeat (5) send_speed(16'hFFFF);
        send_speed(16'd56324);          // one short of closing the loop
        send_speed(16'h0001);           // close the loop exactly
        send_speed(16'h5555);
        send_speed(16'hAAAA);
        wait_for_results();

        load_origin($urandom, $urandom, $urandom);
        random_speeds(PHASE_WORDS);

        send_idle_pct = 50;
        recv_idle_pct = 17;
        load_origin(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0005);
        random_speeds(PHASE_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_origin(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_speeds(PHASE_WORDS);

        $display("Sent %0d speed words over %0d origin settings plus reset origin.",
                 tracker.words, settings);
        $display("Checked %0d position words, %0d segment ends crossed, %0d mismatches.",
                 tracker.checked, tracker.wraps, tracker.errors);
        if (tracker.errors == 0 && tracker.pending_pos.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
